### hw/rtl/dtp_pkg.sv
package dtp_pkg;

  localparam int CHAR_W     = 8;
  localparam int NS_W       = 64;
  localparam int ST_W       = 2;
  localparam int CFG_W      = 5;
  localparam int CNT_W      = 5;
  localparam int PLACES_W   = CNT_W + 1;
  localparam int ULEN_W     = 3;
  localparam int LETTERS_W  = 32;
  localparam int EX_W       = 4;
  localparam int DIGIT_W    = 4;
  localparam int IN_DATA_W  = ((CHAR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NS_W + ST_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - NS_W - ST_W;

  localparam logic [CFG_W-1:0]  MAX_DIGITS_RESET = 5'd9;
  localparam logic [CFG_W-1:0]  MAX_DIGITS_TOP   = 5'd19;
  localparam logic [PLACES_W-1:0] MAX_DIV_EXP    = 6'd19;
  localparam logic [ULEN_W-1:0] UNIT_CHARS       = 3'd4;
  localparam logic [ULEN_W-1:0] UNIT_LEN_MAX     = 3'd5;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CASE_GAP   = 8'h20;

  // unit strings, first character in the low byte
  localparam logic [LETTERS_W-1:0] UNIT_NS   = 32'h0000_736e;
  localparam logic [LETTERS_W-1:0] UNIT_NSEC = 32'h6365_736e;
  localparam logic [LETTERS_W-1:0] UNIT_US   = 32'h0000_7375;
  localparam logic [LETTERS_W-1:0] UNIT_USEC = 32'h6365_7375;
  localparam logic [LETTERS_W-1:0] UNIT_MS   = 32'h0000_736d;
  localparam logic [LETTERS_W-1:0] UNIT_MSEC = 32'h6365_736d;
  localparam logic [LETTERS_W-1:0] UNIT_S    = 32'h0000_0073;
  localparam logic [LETTERS_W-1:0] UNIT_SEC  = 32'h0063_6573;
  localparam logic [LETTERS_W-1:0] UNIT_M    = 32'h0000_006d;
  localparam logic [LETTERS_W-1:0] UNIT_MIN  = 32'h006e_696d;

  localparam logic [EX_W-1:0] EX_US = 4'd3;
  localparam logic [EX_W-1:0] EX_MS = 4'd6;
  localparam logic [EX_W-1:0] EX_S  = 4'd9;

  localparam logic [NS_W-1:0] NS_MAX     = {NS_W{1'b1}};
  localparam logic [NS_W-1:0] MIN_NS     = 64'd60000000000;
  localparam logic [NS_W-1:0] MIN_FRAC_1 = 64'd6000000000;
  localparam logic [NS_W-1:0] MIN_FRAC_2 = 64'd600000000;
  localparam logic [NS_W-1:0] MIN_FRAC_3 = 64'd60000000;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_DIGITS = 2'd1,
    ST_UNIT   = 2'd2,
    ST_OVF    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_INT  = 4'b0001,
    PH_LZ   = 4'b0010,
    PH_FRAC = 4'b0100,
    PH_UNIT = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    U_PLAIN = 2'd0,
    U_SCALE = 2'd1,
    U_MIN   = 2'd2,
    U_BAD   = 2'd3
  } unit_kind_t;

  typedef enum logic [1:0] {
    F_NONE = 2'd0,
    F_MUL  = 2'd1,
    F_DIV  = 2'd2
  } frac_kind_t;

  typedef struct packed {
    logic take;
    logic mul_int;
    logic mul_frac;
    logic div_frac;
    logic cap_v;
    logic cap_f_mul;
    logic cap_f_div;
    logic cap_f_zero;
    logic res_direct;
    logic res_add;
    logic emit;
  } dtp_cmd_t;

  typedef struct packed {
    logic       digits_err;
    unit_kind_t unit_kind;
    frac_kind_t frac_kind;
    logic       mul_done;
    logic       div_done;
  } dtp_stat_t;

  function automatic logic [NS_W-1:0] pow10(input logic [4:0] idx);
    logic [NS_W-1:0] v;
    begin
      case (idx)
        5'd0:  v = 64'd1;
        5'd1:  v = 64'd10;
        5'd2:  v = 64'd100;
        5'd3:  v = 64'd1000;
        5'd4:  v = 64'd10000;
        5'd5:  v = 64'd100000;
        5'd6:  v = 64'd1000000;
        5'd7:  v = 64'd10000000;
        5'd8:  v = 64'd100000000;
        5'd9:  v = 64'd1000000000;
        5'd10: v = 64'd10000000000;
        5'd11: v = 64'd100000000000;
        5'd12: v = 64'd1000000000000;
        5'd13: v = 64'd10000000000000;
        5'd14: v = 64'd100000000000000;
        5'd15: v = 64'd1000000000000000;
        5'd16: v = 64'd10000000000000000;
        5'd17: v = 64'd100000000000000000;
        5'd18: v = 64'd1000000000000000000;
        5'd19: v = 64'd10000000000000000000;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

### hw/rtl/dtp_mul.sv
module dtp_mul import dtp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NS_W-1:0] a,
  input  logic [NS_W-1:0] b,
  output logic [NS_W-1:0] prod,
  output logic            ovf,
  output logic            done
);

  logic [NS_W-1:0] a_sh;
  logic [NS_W-1:0] b_sh;
  logic [NS_W-1:0] acc;
  logic            big;
  logic            ovf_r;
  logic            run;
  logic            done_r;
  logic [NS_W:0]   sum;

  assign sum  = {1'b0, acc} + {1'b0, a_sh};
  assign prod = acc;
  assign ovf  = ovf_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && (b_sh[NS_W-1:1] == '0)) begin
        run    <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // big: the shifted multiplicand no longer fits in NS_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a;
      b_sh  <= b;
      acc   <= '0;
      big   <= 1'b0;
      ovf_r <= 1'b0;
    end else if (run) begin
      if (b_sh[0]) begin
        acc <= sum[NS_W-1:0];
        if (big || sum[NS_W]) begin
          ovf_r <= 1'b1;
        end
      end
      big  <= big | a_sh[NS_W-1];
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

### hw/rtl/dtp_div.sv
module dtp_div import dtp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NS_W-1:0] n,
  input  logic [NS_W-1:0] d,
  output logic [NS_W-1:0] q,
  output logic            done
);

  localparam int DCNT_W = $clog2(NS_W);

  logic [NS_W-1:0]   quo;
  logic [NS_W-1:0]   rem;
  logic [NS_W-1:0]   dv;
  logic [DCNT_W-1:0] cnt;
  logic              run;
  logic              done_r;
  logic [NS_W:0]     rs;
  logic [NS_W:0]     diff;
  logic              ge;

  assign rs   = {rem, quo[NS_W-1]};
  assign ge   = rs >= {1'b0, dv};
  assign diff = rs - {1'b0, dv};
  assign q    = quo;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_r <= 1'b0;
      cnt    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DCNT_W'(NS_W - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run    <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= n;
      rem <= '0;
      dv  <= d;
    end else if (run) begin
      rem <= ge ? diff[NS_W-1:0] : rs[NS_W-1:0];
      quo <= {quo[NS_W-2:0], ge};
    end
  end

endmodule

### hw/rtl/dtp_datapath.sv
module dtp_datapath import dtp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [CHAR_W-1:0] in_char,
  input  dtp_cmd_t          cmd,
  output dtp_stat_t         stat,
  output logic [NS_W-1:0]   out_ns,
  output logic [ST_W-1:0]   out_st
);

  logic [CFG_W-1:0]     max_digits;
  logic [CFG_W-1:0]     eff_digits;

  phase_t               phase, phase_next;
  logic [NS_W-1:0]      ip, ip_next;
  logic [NS_W-1:0]      fv, fv_next;
  logic [CNT_W-1:0]     lzc, lzc_next;
  logic [CNT_W-1:0]     fdc, fdc_next;
  logic [LETTERS_W-1:0] letters, letters_next;
  logic [ULEN_W-1:0]    ulen, ulen_next;
  logic                 ovf_seen, ovf_seen_next;

  logic                 is_digit;
  logic [DIGIT_W-1:0]   dval;
  logic [CHAR_W-1:0]    uc;
  logic                 add_unit;
  logic                 add_frac;
  logic [NS_W+3:0]      ip_x10;
  logic [NS_W-1:0]      ip_mul;
  logic [NS_W:0]        ip_sum;
  logic                 ip_ovf;
  logic [NS_W-1:0]      ip_step;
  logic [NS_W-1:0]      fv_step;

  unit_kind_t           unit_kind;
  logic [EX_W-1:0]      ex;
  frac_kind_t           frac_kind;
  logic [PLACES_W-1:0]  places;
  logic [PLACES_W-1:0]  diff_up;
  logic [PLACES_W-1:0]  diff_dn;
  logic [NS_W-1:0]      frac_const;
  logic [NS_W-1:0]      int_const;
  logic                 digits_err;

  logic [NS_W-1:0]      mul_a;
  logic [NS_W-1:0]      mul_b;
  logic [NS_W-1:0]      mul_prod;
  logic                 mul_ovf;
  logic                 mul_done;
  logic [NS_W-1:0]      div_q;
  logic                 div_done;

  logic [NS_W-1:0]      v;
  logic                 v_ovf;
  logic [NS_W-1:0]      f;
  logic [NS_W:0]        vf_sum;
  logic                 vf_ovf;
  logic [NS_W-1:0]      res_ns;
  status_t              res_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_digits <= MAX_DIGITS_RESET;
    end else if (cfg_we) begin
      max_digits <= cfg_data;
    end
  end

  always_comb begin
    if (max_digits == '0) begin
      eff_digits = CFG_W'(1);
    end else if (max_digits > MAX_DIGITS_TOP) begin
      eff_digits = MAX_DIGITS_TOP;
    end else begin
      eff_digits = max_digits;
    end
  end

  assign is_digit = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign dval     = in_char[DIGIT_W-1:0];
  assign uc       = ((in_char >= CH_UPPER_A) && (in_char <= CH_UPPER_Z)) ?
                    in_char + CASE_GAP : in_char;

  assign ip_x10  = {1'b0, ip, 3'b000} + {3'b000, ip, 1'b0};
  assign ip_mul  = (ip_x10[NS_W+3:NS_W] != '0) ? NS_MAX : ip_x10[NS_W-1:0];
  assign ip_sum  = {1'b0, ip_mul} + {{(NS_W+1-DIGIT_W){1'b0}}, dval};
  assign ip_ovf  = (ip_x10[NS_W+3:NS_W] != '0) || ip_sum[NS_W];
  assign ip_step = ip_ovf ? NS_MAX : ip_sum[NS_W-1:0];
  assign fv_step = {fv[NS_W-4:0], 3'b000} + {fv[NS_W-2:0], 1'b0} +
                   {{(NS_W-DIGIT_W){1'b0}}, dval};

  always_comb begin
    phase_next    = phase;
    ip_next       = ip;
    fv_next       = fv;
    lzc_next      = lzc;
    fdc_next      = fdc;
    letters_next  = letters;
    ulen_next     = ulen;
    ovf_seen_next = ovf_seen;
    add_unit      = 1'b0;
    add_frac      = 1'b0;
    if (cmd.emit) begin
      phase_next    = PH_INT;
      ip_next       = '0;
      fv_next       = '0;
      lzc_next      = '0;
      fdc_next      = '0;
      letters_next  = '0;
      ulen_next     = '0;
      ovf_seen_next = 1'b0;
    end else if (cmd.take) begin
      unique case (phase)
        PH_INT: begin
          if (is_digit) begin
            ip_next       = ip_step;
            ovf_seen_next = ovf_seen | ip_ovf;
          end else if (in_char == CH_POINT) begin
            phase_next = PH_LZ;
          end else begin
            add_unit = 1'b1;
          end
        end
        PH_LZ: begin
          if (in_char == CH_ZERO) begin
            if (lzc != {CNT_W{1'b1}}) begin
              lzc_next = lzc + 1'b1;
            end
          end else if (is_digit) begin
            phase_next = PH_FRAC;
            add_frac   = 1'b1;
          end else begin
            add_unit = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            add_frac = 1'b1;
          end else begin
            add_unit = 1'b1;
          end
        end
        PH_UNIT: begin
          add_unit = 1'b1;
        end
        default: begin
          add_unit = 1'b1;
        end
      endcase
      if (add_frac && (fdc < eff_digits)) begin
        fv_next  = fv_step;
        fdc_next = fdc + 1'b1;
      end
      if (add_unit) begin
        phase_next = PH_UNIT;
        if (ulen < UNIT_CHARS) begin
          letters_next = letters | ({{(LETTERS_W-CHAR_W){1'b0}}, uc} << {ulen[1:0], 3'b000});
        end
        if (ulen != UNIT_LEN_MAX) begin
          ulen_next = ulen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_INT;
      ip       <= '0;
      fv       <= '0;
      lzc      <= '0;
      fdc      <= '0;
      letters  <= '0;
      ulen     <= '0;
      ovf_seen <= 1'b0;
    end else begin
      phase    <= phase_next;
      ip       <= ip_next;
      fv       <= fv_next;
      lzc      <= lzc_next;
      fdc      <= fdc_next;
      letters  <= letters_next;
      ulen     <= ulen_next;
      ovf_seen <= ovf_seen_next;
    end
  end

  always_comb begin
    unit_kind = U_BAD;
    ex        = '0;
    if ((ulen == '0) ||
        ((ulen == 3'd2) && (letters == UNIT_NS)) ||
        ((ulen == 3'd4) && (letters == UNIT_NSEC))) begin
      unit_kind = U_PLAIN;
    end else if (((ulen == 3'd2) && (letters == UNIT_US)) ||
                 ((ulen == 3'd4) && (letters == UNIT_USEC))) begin
      unit_kind = U_SCALE;
      ex        = EX_US;
    end else if (((ulen == 3'd2) && (letters == UNIT_MS)) ||
                 ((ulen == 3'd4) && (letters == UNIT_MSEC))) begin
      unit_kind = U_SCALE;
      ex        = EX_MS;
    end else if (((ulen == 3'd1) && (letters == UNIT_S)) ||
                 ((ulen == 3'd3) && (letters == UNIT_SEC))) begin
      unit_kind = U_SCALE;
      ex        = EX_S;
    end else if (((ulen == 3'd1) && (letters == UNIT_M)) ||
                 ((ulen == 3'd3) && (letters == UNIT_MIN))) begin
      unit_kind = U_MIN;
    end
  end

  assign digits_err = ovf_seen || (ip >= pow10(eff_digits));
  assign places     = {1'b0, lzc} + {1'b0, fdc};
  assign diff_up    = {{(PLACES_W-EX_W){1'b0}}, ex} - places;
  assign diff_dn    = places - {{(PLACES_W-EX_W){1'b0}}, ex};
  assign int_const  = (unit_kind == U_MIN) ? MIN_NS : pow10({1'b0, ex});

  always_comb begin
    frac_kind  = F_NONE;
    frac_const = '0;
    if (fdc != '0) begin
      if (unit_kind == U_MIN) begin
        case (places)
          6'd1: begin
            frac_kind  = F_MUL;
            frac_const = MIN_FRAC_1;
          end
          6'd2: begin
            frac_kind  = F_MUL;
            frac_const = MIN_FRAC_2;
          end
          6'd3: begin
            frac_kind  = F_MUL;
            frac_const = MIN_FRAC_3;
          end
          default: begin
            frac_kind = F_NONE;
          end
        endcase
      end else if (places <= {{(PLACES_W-EX_W){1'b0}}, ex}) begin
        frac_kind  = F_MUL;
        frac_const = pow10(diff_up[4:0]);
      end else if (diff_dn <= MAX_DIV_EXP) begin
        frac_kind  = F_DIV;
        frac_const = pow10(diff_dn[4:0]);
      end
    end
  end

  assign mul_a = cmd.mul_frac ? fv : ip;
  assign mul_b = cmd.mul_frac ? frac_const : int_const;

  dtp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_int | cmd.mul_frac),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .ovf   (mul_ovf),
    .done  (mul_done)
  );

  dtp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_frac),
    .n     (fv),
    .d     (frac_const),
    .q     (div_q),
    .done  (div_done)
  );

  assign vf_sum = {1'b0, v} + {1'b0, f};
  assign vf_ovf = v_ovf | vf_sum[NS_W];

  always_ff @(posedge clk) begin
    if (cmd.cap_v) begin
      v     <= mul_prod;
      v_ovf <= mul_ovf;
    end
    if (cmd.cap_f_mul) begin
      f <= mul_prod;
    end else if (cmd.cap_f_div) begin
      f <= div_q;
    end else if (cmd.cap_f_zero) begin
      f <= '0;
    end
    if (cmd.res_direct) begin
      if (digits_err) begin
        res_ns <= '0;
        res_st <= ST_DIGITS;
      end else if (unit_kind == U_PLAIN) begin
        res_ns <= ip;
        res_st <= ST_OK;
      end else begin
        res_ns <= ip;
        res_st <= ST_UNIT;
      end
    end else if (cmd.res_add) begin
      res_ns <= vf_ovf ? NS_MAX : vf_sum[NS_W-1:0];
      res_st <= vf_ovf ? ST_OVF : ST_OK;
    end
    if (cmd.emit) begin
      out_ns <= res_ns;
      out_st <= res_st;
    end
  end

  assign stat.digits_err = digits_err;
  assign stat.unit_kind  = unit_kind;
  assign stat.frac_kind  = frac_kind;
  assign stat.mul_done   = mul_done;
  assign stat.div_done   = div_done;

endmodule

### hw/rtl/dtp_ctrl.sv
module dtp_ctrl import dtp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  dtp_stat_t stat,
  output dtp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MULV  = 7'b0000100,
    S_MULF  = 7'b0001000,
    S_DIVF  = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_last) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.digits_err || (stat.unit_kind == U_PLAIN) || (stat.unit_kind == U_BAD)) begin
          cmd.res_direct = 1'b1;
          state_next     = S_EMIT;
        end else begin
          cmd.mul_int = 1'b1;
          state_next  = S_MULV;
        end
      end
      S_MULV: begin
        if (stat.mul_done) begin
          cmd.cap_v = 1'b1;
          unique case (stat.frac_kind)
            F_MUL: begin
              cmd.mul_frac = 1'b1;
              state_next   = S_MULF;
            end
            F_DIV: begin
              cmd.div_frac = 1'b1;
              state_next   = S_DIVF;
            end
            default: begin
              cmd.cap_f_zero = 1'b1;
              state_next     = S_ADD;
            end
          endcase
        end
      end
      S_MULF: begin
        if (stat.mul_done) begin
          cmd.cap_f_mul = 1'b1;
          state_next    = S_ADD;
        end
      end
      S_DIVF: begin
        if (stat.div_done) begin
          cmd.cap_f_div = 1'b1;
          state_next    = S_ADD;
        end
      end
      S_ADD: begin
        cmd.res_add = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/decimal_time_with_unit_parser_top.sv
// Characters are accepted back to back until the last one. After it, plain or unknown units
// and digit errors go from the check state straight to the result and output registers;
// scaled units first pass a bit-serial multiplier for the integer part and then the same
// multiplier or a restoring divider for the fraction. The result is loaded into the output
// register once that register is free. The output register holds one result while
// the next string is taken in. Synchronous reset clears the parse state and output valid.
module decimal_time_with_unit_parser_top import dtp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] character
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [63:0] nanoseconds, [65:64] status, rest zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  dtp_cmd_t        cmd;
  dtp_stat_t       stat;
  logic [NS_W-1:0] out_ns;
  logic [ST_W-1:0] out_st;

  assign cfg_ready = 1'b1;

  dtp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .in_char  (s_axis_tdata[CHAR_W-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .out_ns   (out_ns),
    .out_st   (out_st)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_st, out_ns};

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over an untaken result");

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken while finishing a string");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[NS_W+ST_W-1:NS_W] == ST_OVF)) |->
      (m_axis_tdata[NS_W-1:0] == NS_MAX))
    else $error("overflow status without saturated value");

  a_digits_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[NS_W+ST_W-1:NS_W] == ST_DIGITS)) |->
      (m_axis_tdata[NS_W-1:0] == '0))
    else $error("digit error status with nonzero value");

endmodule

### tb/decimal_time_with_unit_parser_top_tb.sv
`timescale 1ns / 100ps

module decimal_time_with_unit_parser_top_tb;
  import dtp_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int ITEMS_PER_STEP = 190;
  localparam int SETTLE_CYCLES  = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int N_SETTINGS     = 9;

  typedef enum logic [1:0] {
    IN_INTEGER   = 2'd0,
    IN_ZEROS     = 2'd1,
    IN_FRACTION  = 2'd2,
    IN_UNIT      = 2'd3
  } parse_phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              lst;
  } char_item_t;

  typedef struct {
    logic [NS_W-1:0] ns;
    status_t         st;
  } duration_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] character
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [63:0] nanoseconds, [65:64] status
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  decimal_time_with_unit_parser_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  char_item_t   chars_pending[$];
  duration_t    durations_due[$];
  int unsigned  mismatches = 0;
  int unsigned  chars_taken = 0;
  int unsigned  durations_checked = 0;
  int unsigned  status_hits[4] = '{0, 0, 0, 0};
  int unsigned  cycles = 0;
  int unsigned  tx_style = 0;
  int unsigned  rx_style = 0;

  string unit_names[11] = '{"", "ns", "nsec", "us", "usec", "ms", "msec",
                            "s", "sec", "m", "min"};
  logic [CFG_W-1:0] setting_list[N_SETTINGS] = '{5'd9, 5'd1, 5'd19, 5'd0, 5'd31,
                                                 5'd25, 5'd5, 5'd9, 5'd14};

  // duration parser shadow
  logic [CFG_W-1:0] max_digits_reg = MAX_DIGITS_RESET;
  parse_phase_t     p_phase = IN_INTEGER;
  logic [NS_W-1:0]  p_int = '0;
  logic [NS_W-1:0]  p_frac = '0;
  int unsigned      p_lz = 0;
  int unsigned      p_fcnt = 0;
  logic [31:0]      p_letters = '0;
  int unsigned      p_ulen = 0;
  bit               p_ovf = 1'b0;

  function automatic int unsigned digits_allowed(logic [CFG_W-1:0] m);
    if (m < 1) return 1;
    if (m > 19) return 19;
    return m;
  endfunction

  function automatic logic [NS_W-1:0] ten_to(int unsigned n);
    logic [NS_W-1:0] v;
    v = 64'd1;
    repeat (n) v = v * 64'd10;
    return v;
  endfunction

  function automatic logic [NS_W-1:0] sat_mul(logic [NS_W-1:0] a, logic [NS_W-1:0] b,
                                              inout bit ovf);
    logic [2*NS_W-1:0] p;
    p = {{NS_W{1'b0}}, a} * {{NS_W{1'b0}}, b};
    if (p[2*NS_W-1:NS_W] != '0) begin
      ovf = 1'b1;
      return NS_MAX;
    end
    return p[NS_W-1:0];
  endfunction

  function automatic logic [NS_W-1:0] sat_add(logic [NS_W-1:0] a, logic [NS_W-1:0] b,
                                              inout bit ovf);
    logic [NS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[NS_W]) begin
      ovf = 1'b1;
      return NS_MAX;
    end
    return s[NS_W-1:0];
  endfunction

  function automatic logic [31:0] packed_unit(string s);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < s.len() && k < 4; k++) v |= 32'(s[k]) << (8 * k);
    return v;
  endfunction

  function automatic bit unit_matches(string s);
    return p_ulen == s.len() && p_letters == packed_unit(s);
  endfunction

  function automatic duration_t duration_now();
    duration_t   r;
    int unsigned places;
    int unsigned ex;
    bit          ovf;
    bit          minutes;
    logic [NS_W-1:0] v;
    logic [NS_W-1:0] f;
    places = p_lz + p_fcnt;
    ovf = 1'b0;
    minutes = 1'b0;
    ex = 0;
    if (p_ovf || p_int >= ten_to(digits_allowed(max_digits_reg))) begin
      r.ns = '0;
      r.st = ST_DIGITS;
      return r;
    end
    if (p_ulen == 0 || unit_matches("ns") || unit_matches("nsec")) begin
      r.ns = p_int;
      r.st = ST_OK;
      return r;
    end
    if (unit_matches("us") || unit_matches("usec")) ex = 3;
    else if (unit_matches("ms") || unit_matches("msec")) ex = 6;
    else if (unit_matches("s") || unit_matches("sec")) ex = 9;
    else if (unit_matches("m") || unit_matches("min")) minutes = 1'b1;
    else begin
      r.ns = p_int;
      r.st = ST_UNIT;
      return r;
    end
    if (minutes) begin
      v = sat_mul(p_int, MIN_NS, ovf);
      if (p_fcnt != 0) begin
        case (places)
          1: v = sat_add(v, p_frac * MIN_FRAC_1, ovf);
          2: v = sat_add(v, p_frac * MIN_FRAC_2, ovf);
          3: v = sat_add(v, p_frac * MIN_FRAC_3, ovf);
          default: ;
        endcase
      end
    end else begin
      v = sat_mul(p_int, ten_to(ex), ovf);
      if (p_fcnt != 0) begin
        f = p_frac;
        if (places <= ex) f = f * ten_to(ex - places);
        else repeat (places - ex) f = f / 64'd10;
        v = sat_add(v, f, ovf);
      end
    end
    r.ns = ovf ? NS_MAX : v;
    r.st = ovf ? ST_OVF : ST_OK;
    return r;
  endfunction

  task automatic add_unit_char(logic [CHAR_W-1:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_GAP;
    if (p_ulen < 4) p_letters |= 32'(c) << (8 * p_ulen);
    if (p_ulen < 5) p_ulen++;
    p_phase = IN_UNIT;
  endtask

  task automatic add_fraction_digit(logic [NS_W-1:0] d);
    if (p_fcnt < digits_allowed(max_digits_reg)) begin
      p_frac = p_frac * 64'd10 + d;
      p_fcnt++;
    end
  endtask

  task automatic consume_char(logic [CHAR_W-1:0] c, logic lst);
    bit              dig;
    bit              ovf;
    logic [NS_W-1:0] d;
    dig = c >= CH_ZERO && c <= CH_NINE;
    d = NS_W'(c) - NS_W'(CH_ZERO);
    ovf = 1'b0;
    case (p_phase)
      IN_INTEGER: begin
        if (dig) begin
          p_int = sat_add(sat_mul(p_int, 64'd10, ovf), d, ovf);
          if (ovf) p_ovf = 1'b1;
        end else if (c == CH_POINT) begin
          p_phase = IN_ZEROS;
        end else begin
          add_unit_char(c);
        end
      end
      IN_ZEROS: begin
        if (c == CH_ZERO) begin
          if (p_lz < 31) p_lz++;
        end else if (dig) begin
          p_phase = IN_FRACTION;
          add_fraction_digit(d);
        end else begin
          add_unit_char(c);
        end
      end
      IN_FRACTION: begin
        if (dig) add_fraction_digit(d);
        else add_unit_char(c);
      end
      default: add_unit_char(c);
    endcase
    if (lst) begin
      durations_due.push_back(duration_now());
      p_phase = IN_INTEGER;
      p_int = '0;
      p_frac = '0;
      p_lz = 0;
      p_fcnt = 0;
      p_letters = '0;
      p_ulen = 0;
      p_ovf = 1'b0;
    end
  endtask

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic int unsigned queue_chars(logic [CHAR_W-1:0] bytes[$]);
    char_item_t it;
    if (bytes.size() == 0) bytes.push_back(CH_ZERO);
    foreach (bytes[k]) begin
      it.ch = bytes[k];
      it.lst = (k == bytes.size() - 1);
      chars_pending.push_back(it);
    end
    return bytes.size();
  endfunction

  function automatic int unsigned queue_text(string s);
    logic [CHAR_W-1:0] bytes[$];
    for (int k = 0; k < s.len(); k++) bytes.push_back(s[k]);
    return queue_chars(bytes);
  endfunction

  function automatic int unsigned queue_random_string(int unsigned eff);
    logic [CHAR_W-1:0] bytes[$];
    int unsigned kind, n, r, u;
    string       unit;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) bytes.push_back($urandom_range(0, 255));
      return queue_chars(bytes);
    end
    r = $urandom_range(0, 19);
    case (r)
      0: n = 0;
      1: n = eff + 1;
      2: n = $urandom_range(20, 22);
      default: n = $urandom_range(1, eff);
    endcase
    if (r == 3) repeat (eff) bytes.push_back(CH_NINE);
    else repeat (n) bytes.push_back(CH_ZERO + $urandom_range(0, 9));
    if ($urandom_range(0, 3) != 0) begin
      bytes.push_back(CH_POINT);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 3);
      repeat (n) bytes.push_back(CH_ZERO);
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, eff + 3) : $urandom_range(0, 4);
      repeat (n) bytes.push_back(CH_ZERO + $urandom_range(0, 9));
    end
    u = $urandom_range(0, 14);
    if (u <= 10) unit = unit_names[u];
    else if (u == 11) begin
      unit = "";
      repeat ($urandom_range(1, 6)) unit = {unit, string'(8'($urandom_range(8'h61, 8'h7a)))};
    end else if (u == 12) begin
      unit = {unit_names[$urandom_range(1, 10)], ($urandom_range(0, 1) ? "." : "5")};
    end else if (u == 13) begin
      unit = "";
    end else begin
      unit = {unit_names[$urandom_range(1, 10)], "s"};
    end
    for (int k = 0; k < unit.len(); k++) begin
      if ($urandom_range(0, 1)) bytes.push_back(unit[k] - CASE_GAP);
      else bytes.push_back(unit[k]);
    end
    if (u == 13) repeat ($urandom_range(1, 5)) bytes.push_back($urandom_range(0, 255));
    return queue_chars(bytes);
  endfunction

  // sender: bursts of items with gaps between them, except in style 0
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  char_item_t  next_char;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        consume_char(s_axis_tdata[CHAR_W-1:0], s_axis_tlast);
        chars_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (burst_left == 0 && gap_left == 0) begin
          case (tx_style)
            0: begin
              burst_left = 64;
              gap_left = 0;
            end
            1: begin
              burst_left = $urandom_range(1, 8);
              gap_left = $urandom_range(0, 3);
            end
            default: begin
              burst_left = $urandom_range(1, 20);
              gap_left = $urandom_range(0, 25);
            end
          endcase
        end
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (chars_pending.size() > 0) begin
          next_char = chars_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IN_DATA_W'(next_char.ch);
          s_axis_tlast <= next_char.lst;
          burst_left--;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern per step, plus long hold-offs
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 30;
  int unsigned rx_tick = 0;

  always @(posedge clk) begin
    rx_tick++;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (next_hold_at != 0 && durations_checked >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at = (next_hold_at == 30) ? 120 : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= (rx_tick % 7) >= 2;
          default: m_axis_tready <= $urandom_range(0, 5) == 0;
        endcase
      end
    end
  end

  duration_t got_due;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      durations_checked++;
      status_hits[m_axis_tdata[NS_W+ST_W-1:NS_W]]++;
      if (durations_due.size() == 0) begin
        flag_mismatch("duration arrived with none expected");
      end else begin
        got_due = durations_due.pop_front();
        if (m_axis_tdata[NS_W-1:0] != got_due.ns)
          flag_mismatch($sformatf("nanoseconds %0d, expected %0d",
                                  m_axis_tdata[NS_W-1:0], got_due.ns));
        if (m_axis_tdata[NS_W+ST_W-1:NS_W] != got_due.st)
          flag_mismatch($sformatf("status %0d, expected %s",
                                  m_axis_tdata[NS_W+ST_W-1:NS_W], got_due.st.name()));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d durations still due",
               cycles, durations_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned added;
    logic [CHAR_W-1:0] odd_bytes[$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      if (ph > 0) begin
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= setting_list[ph];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_digits_reg = setting_list[ph];
      end
      tx_style = ph % 3;
      rx_style = ph % 4;
      added = 0;
      if (ph == 0) begin
        added += queue_text("12.05ms");
        added += queue_text("5.S");
        added += queue_text("1.5m");
        added += queue_text("7x");
        added += queue_text("-3");
        odd_bytes = '{8'h00, 8'hff};
        added += queue_chars(odd_bytes);
        added += queue_text("9nSeC");
      end
      while (added < ITEMS_PER_STEP)
        added += queue_random_string(digits_allowed(max_digits_reg));
      while (chars_pending.size() != 0 || s_axis_tvalid || durations_due.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
    $display("Parsed %0d characters into %0d durations over %0d max_digits settings",
             chars_taken, durations_checked, N_SETTINGS);
    $display("Status mix: ok %0d, too many digits %0d, unknown unit %0d, overflow %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dtp_pkg.sv
hw/rtl/dtp_mul.sv
hw/rtl/dtp_div.sv
hw/rtl/dtp_datapath.sv
hw/rtl/dtp_ctrl.sv
hw/rtl/decimal_time_with_unit_parser_top.sv
tb/decimal_time_with_unit_parser_top_tb.sv
